>>> rtl/microwire_eeprom_master_macros.svh
// Assertion macros for the Microwire EEPROM master RTL.
`ifndef MICROWIRE_EEPROM_MASTER_MACROS_SVH
`define MICROWIRE_EEPROM_MASTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MWE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Microwire master check failed");

// The consequent must hold in the cycle after the antecedent.
`define MWE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Microwire master check failed");

`endif

>>> rtl/mwe_pkg.sv
// Shared types, constants and frame helpers for the Microwire EEPROM master.
package mwe_pkg;

    localparam int ADDR_BITS  = 7;
    localparam int DATA_W     = 16;
    localparam int DATA_W_8   = 8;
    localparam int TICK_W     = 8;
    localparam int CNT_W      = 5;
    localparam int FRAME_W    = 26;
    localparam int FRAME_EXT_W = 1 << CNT_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TICK_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE_16BIT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT_TICKS = 1'd1;

    // Request types
    localparam logic [1:0] REQ_READ   = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_ERASE  = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Microwire opcodes
    localparam logic [1:0] OP_READ  = 2'b10;
    localparam logic [1:0] OP_WRITE = 2'b01;
    localparam logic [1:0] OP_ERASE = 2'b11;
    localparam logic [1:0] OP_EWEN  = 2'b11;

    typedef struct packed {
        logic                 req_valid;
        logic [1:0]           req_type;
        logic [ADDR_BITS-1:0] word_address;
        logic [DATA_W-1:0]    write_data;
        logic                 do_level;
    } req_t;

    typedef struct packed {
        logic              cs_level;
        logic              clk_level;
        logic              di_level;
        logic              busy_res;
        logic              done_res;
        logic [DATA_W-1:0] read_data;
    } res_t;

    function automatic logic [CNT_W-1:0] addr_width(input logic mode_16bit);
        return mode_16bit ? CNT_W'(ADDR_BITS - 1) : CNT_W'(ADDR_BITS);
    endfunction

    function automatic logic [CNT_W-1:0] data_width(input logic mode_16bit);
        return mode_16bit ? CNT_W'(DATA_W) : CNT_W'(DATA_W_8);
    endfunction

    function automatic logic [FRAME_W-1:0] build_cmd(
        input logic                 mode_16bit,
        input logic [1:0]           rtype,
        input logic [ADDR_BITS-1:0] addr,
        input logic [DATA_W-1:0]    data
    );
        logic [CNT_W-1:0]   a;
        logic [CNT_W-1:0]   d;
        logic [1:0]         op;
        logic [FRAME_W-1:0] f;
        a = addr_width(mode_16bit);
        d = data_width(mode_16bit);
        case (rtype)
            REQ_READ:  op = OP_READ;
            REQ_WRITE: op = OP_WRITE;
            default:   op = OP_ERASE;
        endcase
        f = (FRAME_W'(1) << (a + CNT_W'(2))) | (FRAME_W'(op) << a)
            | (FRAME_W'(addr) & ((FRAME_W'(1) << a) - FRAME_W'(1)));
        if (rtype == REQ_WRITE)
        begin
            f = (f << d) | (FRAME_W'(data) & ((FRAME_W'(1) << d) - FRAME_W'(1)));
        end
        return f;
    endfunction

    // Control frame: start bit and 00 opcode, then 11 for EWEN or zeros for EWDS.
    function automatic logic [FRAME_W-1:0] ctrl_frame(input logic mode_16bit,
                                                      input logic enable);
        logic [CNT_W-1:0]   a;
        logic [FRAME_W-1:0] f;
        a = addr_width(mode_16bit);
        f = FRAME_W'(1) << (a + CNT_W'(2));
        if (enable)
        begin
            f = f | (FRAME_W'(OP_EWEN) << (a - CNT_W'(2)));
        end
        return f;
    endfunction

    // Bit counts run from the frame length down to one; zero sends a low level.
    function automatic logic frame_bit(input logic [FRAME_W-1:0] frame,
                                       input logic [CNT_W-1:0] bit_count);
        logic [FRAME_EXT_W-1:0] ext;
        logic [CNT_W-1:0]       idx;
        ext = FRAME_EXT_W'(frame);
        idx = bit_count - CNT_W'(1);
        return (bit_count == '0) ? 1'b0 : ext[idx];
    endfunction

endpackage

>>> rtl/mwe_in_reg.sv
// Input register that holds one request word until the sequencer steps on it.
module mwe_in_reg
    import mwe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  req_t in_word,
    input  logic step_ready,
    output logic step,
    output req_t step_word
);

    logic held_valid_reg;
    logic held_valid_next;
    req_t held_word_reg;
    logic load;

    assign step     = held_valid_reg && step_ready;
    assign in_stall = held_valid_reg && !step_ready;
    assign load     = in_valid && !in_stall;
    assign step_word = held_word_reg;

    always_comb
    begin
        held_valid_next = held_valid_reg;
        if (load)
        begin
            held_valid_next = 1'b1;
        end
        else if (step)
        begin
            held_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            held_word_reg <= in_word;
        end
    end

endmodule

>>> rtl/mwe_core.sv
// Bit-level Microwire sequencer: state registers and one time step of logic.
module mwe_core
    import mwe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              mode_16bit,
    input  logic [TICK_W-1:0] half_bit_ticks,
    input  logic              step,
    input  req_t              step_word,
    output res_t              step_res
);

    `include "microwire_eeprom_master_macros.svh"

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_EN_LO  = 4'd1,
        PH_EN_HI  = 4'd2,
        PH_GAP1   = 4'd3,
        PH_CMD_LO = 4'd4,
        PH_CMD_HI = 4'd5,
        PH_RX_LO  = 4'd6,
        PH_RX_HI  = 4'd7,
        PH_GAP2   = 4'd8,
        PH_POLL   = 4'd9,
        PH_GAP3   = 4'd10,
        PH_DS_LO  = 4'd11,
        PH_DS_HI  = 4'd12
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   bit_count_reg, bit_count_next;
    logic [FRAME_W-1:0] shift_out_reg, shift_out_next;
    logic [DATA_W-1:0]  read_shift_reg, read_shift_next;
    logic [TICK_W-1:0]  tick_count_reg, tick_count_next;
    logic [1:0]         pending_op_reg, pending_op_next;
    logic               write_enabled_reg, write_enabled_next;

    logic [CNT_W-1:0]   a_w;
    logic [CNT_W-1:0]   d_w;
    logic [CNT_W-1:0]   ctrl_len;
    logic [CNT_W-1:0]   cmd_len;
    logic [TICK_W-1:0]  half_len;
    logic [TICK_W-1:0]  tick_inc;
    logic               half_done;
    logic [TICK_W-1:0]  tick_adv;
    logic [DATA_W-1:0]  rx_shifted;
    logic               done;
    logic [DATA_W-1:0]  rdata;
    logic               di;

    assign a_w      = addr_width(mode_16bit);
    assign d_w      = data_width(mode_16bit);
    assign ctrl_len = CNT_W'(3) + a_w;
    assign cmd_len  = ctrl_len + ((pending_op_reg == REQ_WRITE) ? d_w : '0);
    assign half_len = (half_bit_ticks == '0) ? TICK_W'(1) : half_bit_ticks;
    assign tick_inc = tick_count_reg + TICK_W'(1);
    assign half_done = (tick_inc >= half_len);
    assign tick_adv  = half_done ? '0 : tick_inc;
    assign rx_shifted = {read_shift_reg[DATA_W-2:0], step_word.do_level};

    always_comb
    begin
        phase_next         = phase_reg;
        bit_count_next     = bit_count_reg;
        shift_out_next     = shift_out_reg;
        read_shift_next    = read_shift_reg;
        tick_count_next    = tick_adv;
        pending_op_next    = pending_op_reg;
        write_enabled_next = write_enabled_reg;
        done               = 1'b0;
        rdata              = '0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                tick_count_next = '0;
                if (step_word.req_valid && (step_word.req_type != REQ_UNUSED))
                begin
                    pending_op_next = step_word.req_type;
                    shift_out_next  = build_cmd(mode_16bit, step_word.req_type,
                                                step_word.word_address,
                                                step_word.write_data);
                    bit_count_next  = ctrl_len;
                    if (step_word.req_type == REQ_READ)
                    begin
                        phase_next = PH_CMD_LO;
                    end
                    else
                    begin
                        phase_next = PH_EN_LO;
                    end
                end
            end
            PH_EN_LO:
            begin
                if (half_done) phase_next = PH_EN_HI;
            end
            PH_EN_HI:
            begin
                if (half_done)
                begin
                    bit_count_next = bit_count_reg - CNT_W'(1);
                    if (bit_count_next != '0)
                    begin
                        phase_next = PH_EN_LO;
                    end
                    else
                    begin
                        write_enabled_next = 1'b1;
                        phase_next = PH_GAP1;
                    end
                end
            end
            PH_GAP1:
            begin
                if (half_done)
                begin
                    bit_count_next = cmd_len;
                    phase_next = PH_CMD_LO;
                end
            end
            PH_CMD_LO:
            begin
                if (half_done) phase_next = PH_CMD_HI;
            end
            PH_CMD_HI:
            begin
                if (half_done)
                begin
                    bit_count_next = bit_count_reg - CNT_W'(1);
                    if (bit_count_next != '0)
                    begin
                        phase_next = PH_CMD_LO;
                    end
                    else if (pending_op_reg == REQ_READ)
                    begin
                        bit_count_next  = d_w;
                        read_shift_next = '0;
                        phase_next = PH_RX_LO;
                    end
                    else
                    begin
                        phase_next = PH_GAP2;
                    end
                end
            end
            PH_RX_LO:
            begin
                if (half_done) phase_next = PH_RX_HI;
            end
            PH_RX_HI:
            begin
                if (half_done)
                begin
                    read_shift_next = rx_shifted;
                    bit_count_next = bit_count_reg - CNT_W'(1);
                    if (bit_count_next != '0)
                    begin
                        phase_next = PH_RX_LO;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        done  = 1'b1;
                        rdata = rx_shifted;
                    end
                end
            end
            PH_GAP2:
            begin
                if (half_done) phase_next = PH_POLL;
            end
            PH_POLL:
            begin
                // The device holds data-out low until its internal write ends.
                if (half_done && step_word.do_level) phase_next = PH_GAP3;
            end
            PH_GAP3:
            begin
                if (half_done)
                begin
                    bit_count_next = ctrl_len;
                    phase_next = PH_DS_LO;
                end
            end
            PH_DS_LO:
            begin
                if (half_done) phase_next = PH_DS_HI;
            end
            PH_DS_HI:
            begin
                if (half_done)
                begin
                    bit_count_next = bit_count_reg - CNT_W'(1);
                    if (bit_count_next != '0)
                    begin
                        phase_next = PH_DS_LO;
                    end
                    else
                    begin
                        write_enabled_next = 1'b0;
                        phase_next = PH_IDLE;
                        done = 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                tick_count_next = '0;
            end
        endcase
    end

    // Pin levels reflect the state after this step.
    always_comb
    begin
        di = 1'b0;
        case (phase_next) inside
            PH_EN_LO, PH_EN_HI:   di = frame_bit(ctrl_frame(mode_16bit, 1'b1), bit_count_next);
            PH_CMD_LO, PH_CMD_HI: di = frame_bit(shift_out_next, bit_count_next);
            PH_DS_LO, PH_DS_HI:   di = frame_bit(ctrl_frame(mode_16bit, 1'b0), bit_count_next);
            default:              di = 1'b0;
        endcase
    end

    always_comb
    begin
        step_res.cs_level  = (phase_next != PH_IDLE) && (phase_next != PH_GAP1)
                             && (phase_next != PH_GAP2) && (phase_next != PH_GAP3);
        step_res.clk_level = (phase_next == PH_EN_HI) || (phase_next == PH_CMD_HI)
                             || (phase_next == PH_RX_HI) || (phase_next == PH_DS_HI);
        step_res.di_level  = di;
        step_res.busy_res  = (phase_next != PH_IDLE);
        step_res.done_res  = done;
        step_res.read_data = rdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            bit_count_reg     <= '0;
            shift_out_reg     <= '0;
            read_shift_reg    <= '0;
            tick_count_reg    <= '0;
            pending_op_reg    <= '0;
            write_enabled_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            bit_count_reg     <= bit_count_next;
            shift_out_reg     <= shift_out_next;
            read_shift_reg    <= read_shift_next;
            tick_count_reg    <= tick_count_next;
            pending_op_reg    <= pending_op_next;
            write_enabled_reg <= write_enabled_next;
        end
    end

    `MWE_ASSERT_NOW(a_poll_enabled, phase_reg == PH_POLL, write_enabled_reg)
    `MWE_ASSERT_NOW(a_bits_left,
        (phase_reg == PH_EN_LO) || (phase_reg == PH_EN_HI) || (phase_reg == PH_CMD_LO)
        || (phase_reg == PH_CMD_HI) || (phase_reg == PH_RX_LO) || (phase_reg == PH_RX_HI)
        || (phase_reg == PH_DS_LO) || (phase_reg == PH_DS_HI),
        bit_count_reg != '0)
    `MWE_ASSERT_NOW(a_idle_ticks, phase_reg == PH_IDLE, tick_count_reg == '0)
    `MWE_ASSERT_NEXT(a_done_ends, step && done, phase_reg == PH_IDLE)

endmodule

>>> rtl/mwe_out_reg.sv
// Result register that holds one result word until the receiver takes it.
module mwe_out_reg
    import mwe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  res_t step_res,
    output logic step_ready,
    output logic out_valid,
    input  logic out_stall,
    output res_t out_word
);

    logic full_reg;
    logic full_next;
    res_t word_reg;

    // A new word may enter when the register is empty or is being emptied.
    assign step_ready = !full_reg || !out_stall;
    assign full_next  = step ? 1'b1 : (full_reg && out_stall);
    assign out_valid  = full_reg;
    assign out_word   = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            word_reg <= step_res;
        end
    end

endmodule

>>> rtl/microwire_eeprom_master.sv
// Top level of the Microwire 93C46-type EEPROM master.
//
//  Channel   Handshake             Word contents
//  input     in_valid / in_stall   req_valid, req_type, word_address, write_data, do_level
//  output    out_valid / out_stall cs_level, clk_level, di_level, busy_res, done_res, read_data
//  config    cfg_we                cfg_index, cfg_data
//
// One input word is taken per clock while in_stall is low; each is one time step of the sequencer.
// A result word is offered once its input word has passed through the input
// register, the sequencer logic and the result register, in that order.
// Reset leaves the sequencer idle, 8-bit organisation and one tick per half bit.
// A stall on the output holds the result register and, once the input register
// is also full, stalls the input in the same cycle.
module microwire_eeprom_master
    import mwe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_valid,
    input  logic [1:0]            req_type,
    input  logic [ADDR_BITS-1:0]  word_address,
    input  logic [DATA_W-1:0]     write_data,
    input  logic                  do_level,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  cs_level,
    output logic                  clk_level,
    output logic                  di_level,
    output logic                  busy_res,
    output logic                  done_res,
    output logic [DATA_W-1:0]     read_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic              mode_16bit_reg;
    logic [TICK_W-1:0] half_bit_ticks_reg;
    req_t              in_word;
    req_t              step_word;
    res_t              step_res;
    res_t              out_word;
    logic              step;
    logic              step_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_16bit_reg     <= 1'b0;
            half_bit_ticks_reg <= TICK_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE_16BIT:     mode_16bit_reg     <= cfg_data[0];
                REG_HALF_BIT_TICKS: half_bit_ticks_reg <= cfg_data[TICK_W-1:0];
                default:            mode_16bit_reg     <= mode_16bit_reg;
            endcase
        end
    end

    always_comb
    begin
        in_word.req_valid    = req_valid;
        in_word.req_type     = req_type;
        in_word.word_address = word_address;
        in_word.write_data   = write_data;
        in_word.do_level     = do_level;
    end

    mwe_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .step_ready (step_ready),
        .step       (step),
        .step_word  (step_word)
    );

    mwe_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .mode_16bit     (mode_16bit_reg),
        .half_bit_ticks (half_bit_ticks_reg),
        .step           (step),
        .step_word      (step_word),
        .step_res       (step_res)
    );

    mwe_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .step_res   (step_res),
        .step_ready (step_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word)
    );

    assign cs_level  = out_word.cs_level;
    assign clk_level = out_word.clk_level;
    assign di_level  = out_word.di_level;
    assign busy_res  = out_word.busy_res;
    assign done_res  = out_word.done_res;
    assign read_data = out_word.read_data;

endmodule
